>>> hdl/anbf_pkg.sv
// shared types and constants for the annex b nal unit finder
package anbf_pkg;

	localparam int unsigned MAX_BUFFER_BYTES = 65536;
	localparam int unsigned POS_W            = 16;
	localparam int unsigned LEN_W            = 17;
	localparam int unsigned TYPE_W           = 5;
	localparam int unsigned QUEUE_DEPTH      = 2;
	localparam int unsigned QPTR_W           = 1;
	localparam int unsigned QCNT_W           = 2;

	localparam logic [POS_W-1:0] POS_LAST      = POS_W'(MAX_BUFFER_BYTES - 1);
	localparam logic [7:0]       NAL_TYPE_MASK = 8'h1f;
	localparam logic [7:0]       CODE_BYTE     = 8'h01;
	localparam logic [7:0]       ZERO_BYTE     = 8'h00;
	localparam logic [1:0]       ZRUN_MAX      = 2'd3;
	localparam logic [1:0]       ZRUN_SHORT    = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} anbf_in_t;

	typedef struct packed {
		logic [POS_W-1:0]  nal_offset;
		logic [LEN_W-1:0]  nal_length;
		logic [TYPE_W-1:0] nal_type;
		logic              ended_by_buffer_end;
	} anbf_out_t;

	// unit boundary found by the front end, length still to be worked out
	typedef struct packed {
		logic [POS_W-1:0]  unit_start;
		logic [LEN_W-1:0]  unit_end;
		logic [TYPE_W-1:0] unit_type;
		logic              by_end;
	} anbf_event_t;

endpackage

>>> hdl/anbf_front.sv
// byte scanner: tracks start codes and emits unit boundary events
module anbf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  anbf_pkg::anbf_in_t   in_item,
	input  logic                 q_full,
	output logic                 ev_valid,
	output anbf_pkg::anbf_event_t ev_item
);

	logic [anbf_pkg::POS_W-1:0]  pos_q;
	logic [1:0]                  zero_run_q;
	logic                        unit_open_q;
	logic                        awaiting_q;
	logic [anbf_pkg::POS_W-1:0]  unit_start_q;
	logic [anbf_pkg::TYPE_W-1:0] unit_type_q;

	logic                        accept;
	logic [7:0]                  b;
	logic [7:0]                  masked;
	logic [anbf_pkg::TYPE_W-1:0] type_cur;
	logic                        open_cur;
	logic                        is_code;
	logic [anbf_pkg::POS_W-1:0]  back;
	logic [anbf_pkg::POS_W-1:0]  code_start;
	logic [1:0]                  zero_run_d;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign b        = in_item.data_byte;
	assign masked   = b & anbf_pkg::NAL_TYPE_MASK;

	always_comb begin
		type_cur = awaiting_q ? masked[anbf_pkg::TYPE_W-1:0] : unit_type_q;
		open_cur = awaiting_q || unit_open_q;
		is_code  = (b == anbf_pkg::CODE_BYTE) && (zero_run_q >= anbf_pkg::ZRUN_SHORT);
		back     = (zero_run_q == anbf_pkg::ZRUN_MAX) ? anbf_pkg::POS_W'(3)
		                                                : anbf_pkg::POS_W'(2);
		code_start = (pos_q >= back) ? (pos_q - back) : '0;
		if (is_code) begin
			zero_run_d = '0;
		end else if (b == anbf_pkg::ZERO_BYTE) begin
			zero_run_d = (zero_run_q == anbf_pkg::ZRUN_MAX) ? zero_run_q : zero_run_q + 2'd1;
		end else begin
			zero_run_d = '0;
		end
	end

	// a code closes the open unit; otherwise the buffer end closes it
	always_comb begin
		ev_valid = accept && open_cur && (is_code || in_item.last_byte);
		ev_item.unit_start = unit_start_q;
		ev_item.unit_end   = is_code ? {1'b0, code_start}
		                             : {1'b0, pos_q} + anbf_pkg::LEN_W'(1);
		ev_item.unit_type  = type_cur;
		ev_item.by_end     = !is_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			zero_run_q   <= '0;
			unit_open_q  <= 1'b0;
			awaiting_q   <= 1'b0;
			unit_start_q <= '0;
			unit_type_q  <= '0;
		end else if (accept) begin
			if (in_item.last_byte) begin
				pos_q        <= '0;
				zero_run_q   <= '0;
				unit_open_q  <= 1'b0;
				awaiting_q   <= 1'b0;
				unit_start_q <= '0;
				unit_type_q  <= '0;
			end else begin
				if (pos_q != anbf_pkg::POS_LAST) begin
					pos_q <= pos_q + anbf_pkg::POS_W'(1);
				end
				zero_run_q  <= zero_run_d;
				unit_type_q <= type_cur;
				unit_open_q <= is_code ? 1'b0 : open_cur;
				awaiting_q  <= is_code;
				if (is_code) begin
					unit_start_q <= code_start;
				end
			end
		end
	end

endmodule

>>> hdl/anbf_queue.sv
// short event queue between the scanner and the result stage
module anbf_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  anbf_pkg::anbf_event_t push_item,
	output logic                  full,
	input  logic                  pop,
	output logic                  not_empty,
	output anbf_pkg::anbf_event_t head_item
);

	anbf_pkg::anbf_event_t mem_q [anbf_pkg::QUEUE_DEPTH];
	logic [anbf_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [anbf_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [anbf_pkg::QCNT_W-1:0] count_q;
	logic                        do_pop;

	assign full      = (count_q == anbf_pkg::QCNT_W'(anbf_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_pop    = pop && not_empty;
	assign head_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + anbf_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + anbf_pkg::QPTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + anbf_pkg::QCNT_W'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - anbf_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

>>> hdl/anbf_back.sv
// result stage: works out unit length and holds the output item
module anbf_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  ev_valid,
	input  anbf_pkg::anbf_event_t ev_item,
	output logic                  ev_pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output anbf_pkg::anbf_out_t   out_item
);

	logic                          valid_q;
	anbf_pkg::anbf_out_t           item_q;
	logic [anbf_pkg::LEN_W-1:0]    start_ext;
	logic [anbf_pkg::LEN_W-1:0]    length;

	assign out_valid = valid_q;
	assign out_item  = item_q;
	assign ev_pop    = ev_valid && (!valid_q || out_ready);

	// saturated position can put the end before the start
	always_comb begin
		start_ext = {1'b0, ev_item.unit_start};
		length    = (ev_item.unit_end >= start_ext) ? (ev_item.unit_end - start_ext) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ev_pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_pop) begin
			item_q.nal_offset          <= ev_item.unit_start;
			item_q.nal_length          <= length;
			item_q.nal_type            <= ev_item.unit_type;
			item_q.ended_by_buffer_end <= ev_item.by_end;
		end
	end

endmodule

>>> hdl/annexb_nal_unit_finder_unit.sv
// top level of the annex b nal unit finder
// one byte item accepted per cycle while in_ready is high; the byte that closes a unit
// yields its result through the scanner, the event queue and then the output register
// in_ready drops only while the two-entry event queue is full
// arst_n clears scan state, queue pointers and output valid; no clearing pass
module annexb_nal_unit_finder_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  anbf_pkg::anbf_in_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output anbf_pkg::anbf_out_t out_item
);

	logic                  q_full;
	logic                  ev_push;
	anbf_pkg::anbf_event_t ev_push_item;
	logic                  ev_pop;
	logic                  ev_avail;
	anbf_pkg::anbf_event_t ev_head;

	anbf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_full   (q_full),
		.ev_valid (ev_push),
		.ev_item  (ev_push_item)
	);

	anbf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ev_push),
		.push_item (ev_push_item),
		.full      (q_full),
		.pop       (ev_pop),
		.not_empty (ev_avail),
		.head_item (ev_head)
	);

	anbf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev_valid  (ev_avail),
		.ev_item   (ev_head),
		.ev_pop    (ev_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
